@@ hw/rtl/fpa_pkg.sv @@
// Shared types for the fixed-point ALU: opcodes and the per-item result record.
// No dependencies; used by fpa_div_cell and fixed_point_alu_unit.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int DataW = 32;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [DataW-1:0]   result;
        logic               cmp;
        logic               ovf;
        logic               dz;
    } t_info;

endpackage
`default_nettype wire

@@ hw/rtl/fpa_div_cell.sv @@
// One restoring-division cell: one quotient bit per cell, carries the item record along.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int DW = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DataW-1:0] i_rem,
    input  wire logic [DW-1:0]    i_work,
    input  wire logic [DataW-1:0] i_dvs,
    input  wire logic             i_qneg,
    input  wire t_info            i_info,
    output logic                  o_valid,
    output logic [DataW-1:0]      o_rem,
    output logic [DW-1:0]         o_work,
    output logic [DataW-1:0]      o_dvs,
    output logic                  o_qneg,
    output t_info                 o_info
);

    logic [DataW:0]   w_trial;
    logic [DataW:0]   w_diff;
    logic             w_ge;
    logic [DataW-1:0] n_rem;
    logic [DW-1:0]    n_work;

    logic             r_valid;
    logic [DataW-1:0] r_rem;
    logic [DW-1:0]    r_work;
    logic [DataW-1:0] r_dvs;
    logic             r_qneg;
    t_info            r_info;

    always_comb begin
        w_trial = {i_rem, i_work[DW-1]};
        w_diff  = w_trial - {1'b0, i_dvs};
        w_ge    = (w_trial >= {1'b0, i_dvs});
        n_rem   = w_ge ? w_diff[DataW-1:0] : w_trial[DataW-1:0];
        n_work  = {i_work[DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_work <= n_work;
            r_dvs  <= i_dvs;
            r_qneg <= i_qneg;
            r_info <= i_info;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_work  = r_work;
    assign o_dvs   = r_dvs;
    assign o_qneg  = r_qneg;
    assign o_info  = r_info;

endmodule
`default_nettype wire

@@ hw/rtl/fixed_point_alu_unit.sv @@
// Top level of the signed Q fixed-point ALU: operand stage, multiplier, divider cell row.
// Depends on fpa_pkg and fpa_div_cell.
//
//  channel | valid   | ready   | payload
//  input   | i_valid | o_ready | i_func, i_operand_a, i_operand_b
//  output  | o_valid | i_ready | o_result, o_compare_true, o_overflow, o_div_by_zero
//
// One item per cycle unless the output stalls; after the operand stage, items pass
// the row of 32 + FRACTION_BITS division cells, one quotient bit per cell.
// The whole row advances together whenever the output register is empty or being taken.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_unit
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_func,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result,
    output logic             o_compare_true,
    output logic             o_overflow,
    output logic             o_div_by_zero
);

    localparam int DW = DataW + FRACTION_BITS;

    logic w_en;

    logic                    r0_valid;
    t_func                   r0_func;
    logic signed [DataW-1:0] r0_a;
    logic signed [DataW-1:0] r0_b;
    logic signed [63:0]      r0_prod;
    logic [DW-1:0]           r0_dvd;
    logic [DataW-1:0]        r0_dvs;
    logic                    r0_qneg;

    logic [DataW-1:0] w_amag;
    logic [DataW-1:0] w_bmag;

    logic signed [63:0] w_a64;
    logic signed [63:0] w_b64;
    logic signed [63:0] w_s;
    logic [63:0]        w_pmag;
    logic [63:0]        w_psh;
    logic               w_arith;
    logic               w_cmp;
    logic               w_iscmp;
    t_info              w_info0;

    logic             w_valid [0:DW];
    logic [DataW-1:0] w_rem   [0:DW];
    logic [DW-1:0]    w_work  [0:DW];
    logic [DataW-1:0] w_dvs   [0:DW];
    logic             w_qneg  [0:DW];
    t_info            w_info  [0:DW];

    logic signed [DW:0] w_sq;
    t_info              n_out;

    logic  r_out_valid;
    t_info r_out;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    assign w_amag = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
    assign w_bmag = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_func <= t_func'(i_func);
            r0_a    <= $signed(i_operand_a);
            r0_b    <= $signed(i_operand_b);
            r0_prod <= 64'($signed(i_operand_a)) * 64'($signed(i_operand_b));
            r0_dvd  <= {w_amag, {FRACTION_BITS{1'b0}}};
            r0_dvs  <= w_bmag;
            r0_qneg <= i_operand_a[31] ^ i_operand_b[31];
        end
    end

    always_comb begin
        w_a64   = 64'(r0_a);
        w_b64   = 64'(r0_b);
        w_pmag  = r0_prod[63] ? (~r0_prod + 64'd1) : r0_prod;
        w_psh   = w_pmag >> FRACTION_BITS;
        w_s     = '0;
        w_arith = 1'b0;
        w_cmp   = 1'b0;
        w_iscmp = 1'b0;
        unique case (r0_func)
            FN_ADD: begin
                w_s = w_a64 + w_b64;
                w_arith = 1'b1;
            end
            FN_SUB: begin
                w_s = w_a64 - w_b64;
                w_arith = 1'b1;
            end
            FN_MUL: begin
                w_s = r0_prod[63] ? $signed(~w_psh + 64'd1) : $signed(w_psh);
                w_arith = 1'b1;
            end
            FN_DIV: w_s = '0;
            FN_GT: begin
                w_cmp = r0_a > r0_b;
                w_iscmp = 1'b1;
            end
            FN_LT: begin
                w_cmp = r0_a < r0_b;
                w_iscmp = 1'b1;
            end
            FN_GE: begin
                w_cmp = r0_a >= r0_b;
                w_iscmp = 1'b1;
            end
            FN_LE: begin
                w_cmp = r0_a <= r0_b;
                w_iscmp = 1'b1;
            end
            FN_EQ: begin
                w_cmp = r0_a == r0_b;
                w_iscmp = 1'b1;
            end
            FN_NE: begin
                w_cmp = r0_a != r0_b;
                w_iscmp = 1'b1;
            end
            FN_MIN: w_s = (r0_a > r0_b) ? w_b64 : w_a64;
            FN_MAX: w_s = (r0_a > r0_b) ? w_a64 : w_b64;
            FN_INC: begin
                w_s = w_a64 + 64'sd1;
                w_arith = 1'b1;
            end
            FN_DEC: begin
                w_s = w_a64 - 64'sd1;
                w_arith = 1'b1;
            end
            FN_FROM_INT: begin
                w_s = w_a64 <<< FRACTION_BITS;
                w_arith = 1'b1;
            end
            FN_TO_INT: w_s = w_a64 >>> FRACTION_BITS;
            default: w_s = '0;
        endcase
        if (w_iscmp) begin
            w_s = w_cmp ? 64'sd1 : 64'sd0;
        end
        w_info0.func   = r0_func;
        w_info0.result = w_s[DataW-1:0];
        w_info0.cmp    = w_iscmp && w_cmp;
        w_info0.ovf    = w_arith && (w_s[63:DataW-1] != {(65-DataW){w_s[DataW-1]}});
        w_info0.dz     = (r0_func == FN_DIV) && (r0_b == '0);
    end

    assign w_valid[0] = r0_valid;
    assign w_rem[0]   = '0;
    assign w_work[0]  = r0_dvd;
    assign w_dvs[0]   = r0_dvs;
    assign w_qneg[0]  = r0_qneg;
    assign w_info[0]  = w_info0;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        fpa_div_cell #(
            .DW(DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_work  (w_work[g]),
            .i_dvs   (w_dvs[g]),
            .i_qneg  (w_qneg[g]),
            .i_info  (w_info[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_work  (w_work[g+1]),
            .o_dvs   (w_dvs[g+1]),
            .o_qneg  (w_qneg[g+1]),
            .o_info  (w_info[g+1])
        );
    end

    always_comb begin
        w_sq  = w_qneg[DW] ? $signed(~{1'b0, w_work[DW]} + 1'b1) : $signed({1'b0, w_work[DW]});
        n_out = w_info[DW];
        if (w_info[DW].func == FN_DIV && !w_info[DW].dz) begin
            n_out.result = w_sq[DataW-1:0];
            n_out.ovf    = (w_sq[DW:DataW-1] != {(DW-DataW+2){w_sq[DataW-1]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result       = r_out.result;
    assign o_compare_true = r_out.cmp;
    assign o_overflow     = r_out.ovf;
    assign o_div_by_zero  = r_out.dz;

    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dz |-> r_out.func == FN_DIV && r_out.result == '0 && !r_out.ovf)
        else $error("divide-by-zero flag on a bad item");

    a_cmp_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.cmp |-> r_out.result == 32'd1 && !r_out.ovf)
        else $error("compare item carries a bad result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("output item changed while stalled");

endmodule
`default_nettype wire
